@@ rtl/sqlfo_pkg.sv @@
`default_nettype none
package sqlfo_pkg;

   localparam int TABLE_ADDR_BITS = 10;
   localparam int SAMPLE_BITS     = 16;
   localparam int QSIZE           = 1 << TABLE_ADDR_BITS;
   localparam int AMP             = (1 << (SAMPLE_BITS - 1)) - 1;

   localparam int PHASE_BITS    = 32;
   localparam int STEPS_BITS    = 20;
   localparam int RATE_BITS     = 40;
   localparam int RATE_FRAC     = 8;
   localparam int STEP_BITS     = 41;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int REQ_DATA_BITS = 32;
   localparam int REQ_USER_BITS = 4;
   localparam int RSP_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // register indexes
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BRAKE_STEPS   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_RELEASE_STEPS = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CHORUS_STEPS  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TREMOLO_STEPS = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_BRAKE_INC     = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_CHORUS_INC    = 3'd5;

   // reset values
   localparam logic [STEPS_BITS-1:0] RST_RAMP_STEPS = 20'd48000;
   localparam logic [PHASE_BITS-1:0] RST_BRAKE_INC  = 32'd8948;
   localparam logic [PHASE_BITS-1:0] RST_CHORUS_INC = 32'd71583;
   localparam logic [PHASE_BITS-1:0] RST_START_INC  = 32'd89478;
   localparam logic [PHASE_BITS-1:0] RST_LEFT_PHASE = 32'd0;
   localparam logic [PHASE_BITS-1:0] RST_RIGHT_PHASE = 32'h4000_0000;

   typedef enum logic [2:0] {
      FUNC_TICK    = 3'd0,
      FUNC_BRAKE   = 3'd1,
      FUNC_UNBRAKE = 3'd2,
      FUNC_CHORUS  = 3'd3,
      FUNC_TREMOLO = 3'd4,
      FUNC_RECOVER = 3'd5,
      FUNC_ANGLE   = 3'd6
   } func_type;

   typedef struct packed {
      logic load;
      logic event_go;
      logic step_load;
      logic tick_rate;
      logic tick_left;
      logic tick_right;
      logic emit;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     need_div;
      logic     div_done;
   } status_type;

   typedef logic [SAMPLE_BITS-2:0] quarter_tab_type [0:QSIZE];

   // shift and subtract quotient
   function automatic longint unsigned long_quo(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = 64'd0;
      rem = 64'd0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         quo = {quo[62:0], 1'b0};
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 64'd1;
         end
      end
      return quo;
   endfunction

   // quarter-wave sine, truncating taylor series in q30, scaled to the sample range
   function automatic quarter_tab_type build_quarter();
      quarter_tab_type tab;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned term;
      longint unsigned den;
      longint unsigned v;
      longint          sum;
      int              i;
      int              k;
      for (i = 0; i <= QSIZE; i++) begin
         t    = (longint'(i) * HALF_PI_Q30) >> TABLE_ADDR_BITS;
         t2   = (t * t) >> 30;
         term = t;
         sum  = longint'(t);
         for (k = 1; k <= 9; k++) begin
            den  = longint'((2 * k) * (2 * k + 1));
            term = long_quo((term * t2) >> 30, den);
            if ((k & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = ((longint'(sum) * longint'(AMP)) + (64'd1 << 29)) >> 30;
         if (v > longint'(AMP)) begin
            v = longint'(AMP);
         end
         tab[i] = v[SAMPLE_BITS-2:0];
      end
      return tab;
   endfunction

endpackage
`default_nettype wire

@@ rtl/smoothed_quadrature_lfo_top.sv @@
// sequence: a tick item's result is registered after the ramp step and the left and
// right quarter-wave rom reads, an event item's after decode, or after the bit-serial
// divider when the ramp step is recomputed
// flow: one item at a time; a new item is accepted only after the last is emitted
// reset: synchronous; restores registers and oscillator state to their defaults
`default_nettype none
module smoothed_quadrature_lfo_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [sqlfo_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // value
   input  wire logic [sqlfo_pkg::REQ_USER_BITS-1:0]   req_tuser,  // func, stereo
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic      [sqlfo_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,  // left_sample, right_sample
   output logic                                       rsp_tuser,  // right_valid
   input  wire logic                                  csr_we,
   input  wire logic [sqlfo_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [sqlfo_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sqlfo_pkg::*;

   cmd_type    cmd;
   status_type status;

   sqlfo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   sqlfo_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule
`default_nettype wire

@@ rtl/sqlfo_div.sv @@
`default_nettype none
module sqlfo_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [sqlfo_pkg::RATE_BITS-1:0]      dividend,
   input  wire logic                                 negative,
   input  wire logic [sqlfo_pkg::STEPS_BITS-1:0]     divisor,
   output logic                                      done,
   output logic      [sqlfo_pkg::STEP_BITS-1:0]      quotient
);
   import sqlfo_pkg::*;

   localparam int CNT_BITS = $clog2(RATE_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(RATE_BITS - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [STEPS_BITS-1:0] rem_ff, rem_in;
   logic [RATE_BITS-1:0]  quo_ff, quo_in;
   logic [STEPS_BITS-1:0] div_ff, div_in;
   logic                  neg_ff, neg_in;
   logic [STEPS_BITS:0]   shifted;
   logic [STEPS_BITS:0]   trial;
   logic                  fits;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      shifted = {rem_ff, quo_ff[RATE_BITS-1]};
      trial   = shifted - {1'b0, div_ff};
      fits    = (shifted >= {1'b0, div_ff});
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         neg_in  = negative;
      end else if (busy_ff) begin
         rem_in = fits ? trial[STEPS_BITS-1:0] : shifted[STEPS_BITS-1:0];
         quo_in = {quo_ff[RATE_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~{1'b0, quo_ff} + 1'b1) : {1'b0, quo_ff};

endmodule
`default_nettype wire

@@ rtl/sqlfo_dp.sv @@
`default_nettype none
module sqlfo_dp (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire sqlfo_pkg::cmd_type                    cmd,
   output sqlfo_pkg::status_type                      status,
   input  wire logic [sqlfo_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  wire logic [sqlfo_pkg::REQ_USER_BITS-1:0]   req_tuser,
   output logic      [sqlfo_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                       rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic [sqlfo_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  wire logic [sqlfo_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import sqlfo_pkg::*;

   localparam quarter_tab_type QUARTER_TAB = build_quarter();

   // configuration
   logic [STEPS_BITS-1:0] brake_steps_ff, release_steps_ff, chorus_steps_ff, tremolo_steps_ff;
   logic [PHASE_BITS-1:0] brake_inc_ff, chorus_inc_ff;

   // oscillator state
   logic [PHASE_BITS-1:0] left_phase_ff, right_phase_ff;
   logic [RATE_BITS-1:0]  rate_now_ff;
   logic [PHASE_BITS-1:0] rate_target_ff;
   logic [STEP_BITS-1:0]  rate_step_ff;
   logic [STEPS_BITS-1:0] steps_left_ff;
   logic [STEPS_BITS-1:0] ramp_length_ff;
   logic [PHASE_BITS-1:0] saved_rate_ff;

   // item and work registers
   func_type                func_ff;
   logic                    stereo_ff;
   logic [PHASE_BITS-1:0]   value_ff;
   logic [PHASE_BITS-1:0]   inc_ff;
   logic [SAMPLE_BITS-2:0]  rom_q_ff;
   logic                    sign_ff;
   logic [SAMPLE_BITS-1:0]  left_res_ff, right_res_ff;
   logic                    rvalid_res_ff;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff;
   logic                    rsp_user_ff;

   // event decode
   logic                  at_chorus;
   logic                  do_rearm;
   logic [STEPS_BITS-1:0] rearm_len;
   logic                  do_target;
   logic [PHASE_BITS-1:0] target;
   logic                  do_save;
   logic [PHASE_BITS-1:0] save_val;
   logic [STEPS_BITS-1:0] len_eff;
   logic [RATE_BITS-1:0]  now_eff;
   logic                  tgt_change;
   logic                  need_div;
   logic [STEP_BITS-1:0]  diff;
   logic [STEP_BITS-1:0]  diff_mag;

   // tick
   logic [RATE_BITS-1:0]  now_next;
   logic [PHASE_BITS-1:0] inc_in;
   logic [PHASE_BITS-1:0] rom_phase;
   logic [TABLE_ADDR_BITS-1:0] rom_pos;
   logic [TABLE_ADDR_BITS:0]   rom_idx;
   logic [SAMPLE_BITS-1:0]  rom_mag;
   logic [SAMPLE_BITS-1:0]  sample;

   logic                  div_done;
   logic [STEP_BITS-1:0]  div_quo;

   always_comb begin
      at_chorus = (rate_target_ff >= chorus_inc_ff);
      do_rearm  = 1'b0;
      rearm_len = ramp_length_ff;
      do_target = 1'b0;
      target    = rate_target_ff;
      do_save   = 1'b0;
      save_val  = saved_rate_ff;
      case (func_ff)
         FUNC_BRAKE: begin
            do_rearm  = 1'b1;
            rearm_len = brake_steps_ff;
            do_target = 1'b1;
            target    = brake_inc_ff;
         end
         FUNC_UNBRAKE: begin
            do_rearm  = 1'b1;
            rearm_len = release_steps_ff;
            do_target = 1'b1;
            target    = saved_rate_ff;
         end
         FUNC_CHORUS: begin
            do_rearm  = at_chorus;
            rearm_len = chorus_steps_ff;
            do_target = 1'b1;
            target    = chorus_inc_ff;
            do_save   = 1'b1;
            save_val  = chorus_inc_ff;
         end
         FUNC_TREMOLO: begin
            do_rearm  = at_chorus;
            rearm_len = tremolo_steps_ff;
            do_target = at_chorus;
            target    = value_ff;
            do_save   = at_chorus;
            save_val  = value_ff;
         end
         FUNC_RECOVER: begin
            do_rearm  = 1'b1;
            rearm_len = tremolo_steps_ff;
            do_target = 1'b1;
            target    = saved_rate_ff;
         end
         default: begin
            do_rearm = 1'b0;
         end
      endcase
      len_eff    = do_rearm ? rearm_len : ramp_length_ff;
      now_eff    = do_rearm ? {rate_target_ff, {RATE_FRAC{1'b0}}} : rate_now_ff;
      tgt_change = do_target && (target != rate_target_ff);
      need_div   = tgt_change && (len_eff != '0);
      diff       = {1'b0, target, {RATE_FRAC{1'b0}}} - {1'b0, now_eff};
      diff_mag   = diff[STEP_BITS-1] ? (~diff + 1'b1) : diff;
   end

   always_comb begin
      now_next = (steps_left_ff == STEPS_BITS'(1)) ? {rate_target_ff, {RATE_FRAC{1'b0}}}
                                                   : rate_now_ff + rate_step_ff[RATE_BITS-1:0];
      inc_in   = (steps_left_ff == '0) ? rate_target_ff : now_next[RATE_BITS-1:RATE_FRAC];
      rom_phase = cmd.tick_left ? right_phase_ff : left_phase_ff;
      rom_pos   = rom_phase[PHASE_BITS-3 -: TABLE_ADDR_BITS];
      rom_idx   = rom_phase[PHASE_BITS-2] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, rom_pos})
                                          : {1'b0, rom_pos};
      rom_mag   = {1'b0, rom_q_ff};
      sample    = sign_ff ? (~rom_mag + 1'b1) : rom_mag;
   end

   sqlfo_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.event_go & need_div),
      .dividend (diff_mag[RATE_BITS-1:0]),
      .negative (diff[STEP_BITS-1]),
      .divisor  (len_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // quarter-wave rom
   always_ff @(posedge clock) begin
      rom_q_ff <= QUARTER_TAB[rom_idx];
      sign_ff  <= rom_phase[PHASE_BITS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_steps_ff   <= RST_RAMP_STEPS;
         release_steps_ff <= RST_RAMP_STEPS;
         chorus_steps_ff  <= RST_RAMP_STEPS;
         tremolo_steps_ff <= RST_RAMP_STEPS;
         brake_inc_ff     <= RST_BRAKE_INC;
         chorus_inc_ff    <= RST_CHORUS_INC;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BRAKE_STEPS:   brake_steps_ff   <= csr_wdata[STEPS_BITS-1:0];
            CSR_RELEASE_STEPS: release_steps_ff <= csr_wdata[STEPS_BITS-1:0];
            CSR_CHORUS_STEPS:  chorus_steps_ff  <= csr_wdata[STEPS_BITS-1:0];
            CSR_TREMOLO_STEPS: tremolo_steps_ff <= csr_wdata[STEPS_BITS-1:0];
            CSR_BRAKE_INC:     brake_inc_ff     <= csr_wdata[PHASE_BITS-1:0];
            CSR_CHORUS_INC:    chorus_inc_ff    <= csr_wdata[PHASE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_phase_ff  <= RST_LEFT_PHASE;
         right_phase_ff <= RST_RIGHT_PHASE;
         rate_now_ff    <= {RST_START_INC, {RATE_FRAC{1'b0}}};
         rate_target_ff <= RST_START_INC;
         rate_step_ff   <= '0;
         steps_left_ff  <= '0;
         ramp_length_ff <= RST_RAMP_STEPS;
         saved_rate_ff  <= RST_START_INC;
      end else begin
         if (cmd.event_go) begin
            if (do_rearm) begin
               ramp_length_ff <= rearm_len;
               rate_now_ff    <= now_eff;
               steps_left_ff  <= '0;
            end
            if (tgt_change) begin
               rate_target_ff <= target;
               if (len_eff == '0) begin
                  rate_now_ff   <= {target, {RATE_FRAC{1'b0}}};
                  steps_left_ff <= '0;
               end else begin
                  steps_left_ff <= len_eff;
               end
            end
            if (do_save) begin
               saved_rate_ff <= save_val;
            end
            if (func_ff == FUNC_ANGLE) begin
               right_phase_ff <= left_phase_ff + value_ff;
            end
         end
         if (cmd.step_load) begin
            rate_step_ff <= div_quo;
         end
         if (cmd.tick_rate && (steps_left_ff != '0)) begin
            steps_left_ff <= steps_left_ff - 1'b1;
            rate_now_ff   <= now_next;
         end
         if (cmd.tick_left) begin
            left_phase_ff <= left_phase_ff + inc_ff;
         end
         if (cmd.tick_right) begin
            right_phase_ff <= right_phase_ff + inc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff       <= func_type'(req_tuser[2:0]);
         stereo_ff     <= req_tuser[3];
         value_ff      <= req_tdata[PHASE_BITS-1:0];
         left_res_ff   <= '0;
         right_res_ff  <= '0;
         rvalid_res_ff <= 1'b0;
      end
      if (cmd.tick_rate) begin
         inc_ff <= inc_in;
      end
      if (cmd.tick_left) begin
         left_res_ff <= sample;
      end
      if (cmd.tick_right && stereo_ff) begin
         right_res_ff  <= sample;
         rvalid_res_ff <= 1'b1;
      end
      if (cmd.emit) begin
         rsp_data_ff <= RSP_DATA_BITS'({right_res_ff, left_res_ff});
         rsp_user_ff <= rvalid_res_ff;
      end
   end

   assign status.func     = func_ff;
   assign status.need_div = need_div;
   assign status.div_done = div_done;
   assign rsp_tdata       = rsp_data_ff;
   assign rsp_tuser       = rsp_user_ff;

endmodule
`default_nettype wire

@@ rtl/sqlfo_ctrl.sv @@
`default_nettype none
module sqlfo_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output sqlfo_pkg::cmd_type          cmd,
   input  wire sqlfo_pkg::status_type  status
);
   import sqlfo_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_TICK_RATE,
      ST_TICK_LEFT,
      ST_TICK_RIGHT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      out_free     = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.func == FUNC_TICK) begin
               state_in = ST_TICK_RATE;
            end else begin
               cmd.event_go = 1'b1;
               state_in     = status.need_div ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.step_load = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_TICK_RATE: begin
            cmd.tick_rate = 1'b1;
            state_in      = ST_TICK_LEFT;
         end
         ST_TICK_LEFT: begin
            cmd.tick_left = 1'b1;
            state_in      = ST_TICK_RIGHT;
         end
         ST_TICK_RIGHT: begin
            cmd.tick_right = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire
